FILE: sv/falu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// falu_pkg
// Types and constants shared by the fixed-point ALU modules.
// ----------------------------------------------------------------------------
package falu_pkg;

    typedef enum logic [3:0] {
        MODE_ADD      = 4'd0,
        MODE_SUB      = 4'd1,
        MODE_MUL      = 4'd2,
        MODE_DIV      = 4'd3,
        MODE_GT       = 4'd4,
        MODE_LT       = 4'd5,
        MODE_GE       = 4'd6,
        MODE_LE       = 4'd7,
        MODE_EQ       = 4'd8,
        MODE_NE       = 4'd9,
        MODE_MIN      = 4'd10,
        MODE_MAX      = 4'd11,
        MODE_INC      = 4'd12,
        MODE_DEC      = 4'd13,
        MODE_TO_INT   = 4'd14,
        MODE_FROM_INT = 4'd15
    } t_mode;

    localparam logic signed [31:0] FX_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] FX_MIN = 32'sh8000_0000;

    // quotient bits produced by the divider, one per stage
    localparam int QUOT_BITS = 32;

    typedef struct packed {
        t_mode              mode;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } t_alu_in;

    typedef struct packed {
        logic signed [31:0] result;
        logic               compare_true;
        logic               overflow;
        logic               divide_by_zero;
    } t_alu_out;

    // sideband that travels with each word down the pipeline
    typedef struct packed {
        logic               valid;
        logic               is_div;
        logic               neg;
        logic               dz;
        logic               big;
        logic signed [31:0] result;
        logic               cmp;
        logic               ovf;
    } t_side;

endpackage

FILE: sv/fixed_point_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_alu
// Signed 32-bit fixed-point ALU: add, sub, mul, div, compares, min/max,
// inc/dec and integer conversion, with saturation and error flags.
// ----------------------------------------------------------------------------
// A word may be started on every clock; busy is never raised. Each result
// appears on o_word with o_strobe for one cycle, in order. The depth of the
// pipeline is set by the divider, which spends one pipeline stage per
// quotient bit (32 stages) plus a range check stage; every operation travels
// the same path so results never reorder.
// ----------------------------------------------------------------------------
module fixed_point_alu import falu_pkg::*; #(
    parameter int FRACTION_BITS = 8
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_alu_in  i_word,
    output logic     o_strobe,
    output t_alu_out o_word
);

    // input stage
    logic               r_v0;
    t_mode              r_mode;
    logic signed [31:0] r_a;
    logic signed [31:0] r_b;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= start;
        end
        r_mode <= i_word.mode;
        r_a    <= i_word.operand_a;
        r_b    <= i_word.operand_b;
    end

    // stage one: simple operations and divider operands
    t_side              n_side1;
    t_side              r_side1;
    logic        [63:0] n_num;
    logic        [32:0] n_den;
    logic        [63:0] r_num1;
    logic        [32:0] r_den1;
    logic signed [32:0] sum;
    logic signed [32:0] dif;
    logic signed [63:0] fi;
    logic        [31:0] ma;
    logic        [31:0] mb;

    always_comb begin
        sum = {r_a[31], r_a} + {r_b[31], r_b};
        dif = {r_a[31], r_a} - {r_b[31], r_b};
        fi  = {{32{r_a[31]}}, r_a} <<< FRACTION_BITS;
        ma  = r_a[31] ? 32'(-r_a) : 32'(r_a);
        mb  = r_b[31] ? 32'(-r_b) : 32'(r_b);
        n_num = ({32'd0, ma} << (FRACTION_BITS + 1)) + {32'd0, mb};
        n_den = {mb, 1'b0};

        n_side1        = '0;
        n_side1.valid  = r_v0;
        n_side1.is_div = (r_mode == MODE_DIV);
        n_side1.neg    = r_a[31] ^ r_b[31];
        n_side1.dz     = (r_mode == MODE_DIV) && (r_b == 32'sd0);
        unique case (r_mode)
            MODE_ADD: begin
                if (sum[32] != sum[31]) begin
                    n_side1.result = sum[32] ? FX_MIN : FX_MAX;
                    n_side1.ovf = 1'b1;
                end else begin
                    n_side1.result = sum[31:0];
                end
            end
            MODE_SUB: begin
                if (dif[32] != dif[31]) begin
                    n_side1.result = dif[32] ? FX_MIN : FX_MAX;
                    n_side1.ovf = 1'b1;
                end else begin
                    n_side1.result = dif[31:0];
                end
            end
            MODE_DIV: begin
                if (r_b == 32'sd0) begin
                    n_side1.result = r_a[31] ? FX_MIN : FX_MAX;
                end
            end
            MODE_GT:  n_side1.cmp = (r_a >  r_b);
            MODE_LT:  n_side1.cmp = (r_a <  r_b);
            MODE_GE:  n_side1.cmp = (r_a >= r_b);
            MODE_LE:  n_side1.cmp = (r_a <= r_b);
            MODE_EQ:  n_side1.cmp = (r_a == r_b);
            MODE_NE:  n_side1.cmp = (r_a != r_b);
            MODE_MIN: n_side1.result = (r_a <= r_b) ? r_a : r_b;
            MODE_MAX: n_side1.result = (r_a >= r_b) ? r_a : r_b;
            MODE_INC: begin
                if (r_a == FX_MAX) begin
                    n_side1.result = FX_MAX;
                    n_side1.ovf = 1'b1;
                end else begin
                    n_side1.result = r_a + 32'sd1;
                end
            end
            MODE_DEC: begin
                if (r_a == FX_MIN) begin
                    n_side1.result = FX_MIN;
                    n_side1.ovf = 1'b1;
                end else begin
                    n_side1.result = r_a - 32'sd1;
                end
            end
            MODE_TO_INT: n_side1.result = r_a >>> FRACTION_BITS;
            MODE_FROM_INT: begin
                if (fi[63:31] != {33{fi[63]}}) begin
                    n_side1.result = fi[63] ? FX_MIN : FX_MAX;
                    n_side1.ovf = 1'b1;
                end else begin
                    n_side1.result = fi[31:0];
                end
            end
            default: ;
        endcase
    end

    logic               r_mul1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side1.valid <= 1'b0;
        end else begin
            r_side1 <= n_side1;
        end
        r_num1 <= n_num;
        r_den1 <= n_den;
        r_mul1 <= (r_mode == MODE_MUL);
    end

    // multiplier runs alongside the input stage and stage one
    logic signed [31:0] mul_result;
    logic               mul_ovf;

    falu_mul #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_mul (
        .i_clk      (i_clk),
        .i_a        (i_word.operand_a),
        .i_b        (i_word.operand_b),
        .o_result   (mul_result),
        .o_overflow (mul_ovf)
    );

    // stage two: merge the multiply result
    t_side       n_side2;
    t_side       r_side2;
    logic [63:0] r_num2;
    logic [32:0] r_den2;

    always_comb begin
        n_side2 = r_side1;
        if (r_mul1) begin
            n_side2.result = mul_result;
            n_side2.ovf    = mul_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side2.valid <= 1'b0;
        end else begin
            r_side2 <= n_side2;
        end
        r_num2 <= r_num1;
        r_den2 <= r_den1;
    end

    // divider pipeline carries every word
    t_side       div_side;
    logic [31:0] div_quot;

    falu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_side  (r_side2),
        .i_num   (r_num2),
        .i_den   (r_den2),
        .o_side  (div_side),
        .o_quot  (div_quot)
    );

    // output stage: sign and saturate the quotient of a divide, register every word
    t_alu_out n_out;
    t_alu_out r_out;
    logic     r_strobe;

    always_comb begin
        n_out.result         = div_side.result;
        n_out.compare_true   = div_side.cmp;
        n_out.overflow       = div_side.ovf;
        n_out.divide_by_zero = div_side.dz;
        if (div_side.is_div && !div_side.dz) begin
            if (div_side.neg) begin
                if (div_side.big || (div_quot > 32'h8000_0000)) begin
                    n_out.result   = FX_MIN;
                    n_out.overflow = 1'b1;
                end else begin
                    n_out.result = 32'(-div_quot);
                end
            end else begin
                if (div_side.big || div_quot[31]) begin
                    n_out.result   = FX_MAX;
                    n_out.overflow = 1'b1;
                end else begin
                    n_out.result = div_quot;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= div_side.valid;
        end
        r_out <= n_out;
    end

    assign o_strobe = r_strobe;
    assign o_word   = r_out;

endmodule

FILE: sv/falu_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// falu_mul
// Two-stage signed multiply with round to nearest (ties away from zero)
// and saturation to 32 bits.
// ----------------------------------------------------------------------------
module falu_mul import falu_pkg::*; #(
    parameter int FRACTION_BITS = 8
) (
    input  logic               i_clk,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    output logic signed [31:0] o_result,
    output logic               o_overflow
);

    localparam logic [63:0] HALF = 64'd1 << (FRACTION_BITS - 1);

    logic signed [63:0] r_prod;
    logic signed [31:0] r_result;
    logic               r_ovf;
    logic        [63:0] mag;
    logic        [63:0] rnd;
    logic signed [31:0] n_result;
    logic               n_ovf;

    // stage one: full product
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    // stage two: magnitude, round, saturate
    always_comb begin
        mag = r_prod[63] ? 64'(-r_prod) : 64'(r_prod);
        rnd = (mag + HALF) >> FRACTION_BITS;
        n_ovf = 1'b0;
        if (r_prod[63]) begin
            if (rnd > 64'h8000_0000) begin
                n_result = FX_MIN;
                n_ovf = 1'b1;
            end else begin
                n_result = 32'(-rnd);
            end
        end else begin
            if (rnd > 64'h7FFF_FFFF) begin
                n_result = FX_MAX;
                n_ovf = 1'b1;
            end else begin
                n_result = rnd[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        r_ovf    <= n_ovf;
    end

    assign o_result   = r_result;
    assign o_overflow = r_ovf;

endmodule

FILE: sv/falu_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// falu_div
// Pipelined restoring divider: a range check stage, then one quotient bit
// per stage, most significant first.
// ----------------------------------------------------------------------------
module falu_div import falu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_side       i_side,
    input  logic [63:0] i_num,
    input  logic [32:0] i_den,
    output t_side       o_side,
    output logic [31:0] o_quot
);

    t_side       r_side [0:QUOT_BITS];
    logic [63:0] r_rem  [0:QUOT_BITS];
    logic [32:0] r_den  [0:QUOT_BITS];
    logic [31:0] r_q    [0:QUOT_BITS];
    t_side       n_side0;

    // range check: quotient of 2^32 or more always saturates
    always_comb begin
        n_side0 = i_side;
        n_side0.big = ({1'b0, i_num} >= ({32'd0, i_den} << QUOT_BITS));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side[0].valid <= 1'b0;
        end else begin
            r_side[0] <= n_side0;
        end
        r_rem[0] <= i_num;
        r_den[0] <= i_den;
        r_q[0]   <= '0;
    end

    // one trial subtract per stage
    for (genvar j = 1; j <= QUOT_BITS; j++) begin : g_stage
        localparam int K = QUOT_BITS - j;
        logic [64:0] diff;
        logic [31:0] qbit;

        always_comb begin
            diff = {1'b0, r_rem[j-1]} - ({32'd0, r_den[j-1]} << K);
            qbit = 32'd1 << K;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[j].valid <= 1'b0;
            end else begin
                r_side[j] <= r_side[j-1];
            end
            r_den[j] <= r_den[j-1];
            if (!diff[64]) begin
                r_rem[j] <= diff[63:0];
                r_q[j]   <= r_q[j-1] | qbit;
            end else begin
                r_rem[j] <= r_rem[j-1];
                r_q[j]   <= r_q[j-1];
            end
        end
    end

    assign o_side = r_side[QUOT_BITS];
    assign o_quot = r_q[QUOT_BITS];

endmodule

FILE: sv/falu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// falu_checker
// Port-level checks on the fixed-point ALU, bound to the top level.
// ----------------------------------------------------------------------------
module falu_checker import falu_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     busy,
    input logic     o_strobe,
    input t_alu_out o_word
);

    // never refuses a word
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy) else $error("busy raised");

    // the two error flags exclude each other
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !(o_word.overflow && o_word.divide_by_zero))
        else $error("overflow with divide by zero");

    // a true compare carries a zero result and no overflow
    a_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_word.compare_true) |->
            (o_word.result == 32'sd0 && !o_word.overflow))
        else $error("compare word with result");

    // divide by zero always saturates
    a_dz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_word.divide_by_zero) |->
            (o_word.result == FX_MAX || o_word.result == FX_MIN))
        else $error("divide by zero not saturated");

    // overflow always saturates
    a_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_word.overflow) |->
            (o_word.result == FX_MAX || o_word.result == FX_MIN))
        else $error("overflow not saturated");

endmodule

bind fixed_point_alu falu_checker u_falu_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_word   (o_word)
);

FILE: dv/tb_fixed_point_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fixed_point_alu
// Self-checking bench for the fixed-point ALU: directed corner words, then
// random words of every operation, each result checked against a predictor.
// ----------------------------------------------------------------------------
module tb_fixed_point_alu;
    import falu_pkg::*;

    localparam int FRAC       = 8;
    localparam int N_RANDOM   = 1800;
    localparam int WDOG_LIMIT = 2000;
    localparam int DRAIN      = 60;

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    logic     busy;
    t_alu_in  i_word;
    logic     o_strobe;
    t_alu_out o_word;

    t_alu_in  pending_words[$];
    t_alu_out expected_results[$];
    int       n_errors;
    int       n_sent;
    int       n_checked;
    int       idle_cycles;
    bit       drain_hold;
    bit       idle_on;

    fixed_point_alu #(.FRACTION_BITS(FRAC)) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_word   (i_word),
        .o_strobe (o_strobe),
        .o_word   (o_word)
    );

    // clock
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // saturate a wide value into the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v,
                                                 inout logic ovf);
        if (v > 66'sd2147483647) begin
            ovf = 1'b1;
            return FX_MAX;
        end
        if (v < -66'sd2147483648) begin
            ovf = 1'b1;
            return FX_MIN;
        end
        return v[31:0];
    endfunction

    // exact fixed-point result for one word
    function automatic t_alu_out alu_predict(input t_alu_in w);
        t_alu_out           r;
        logic signed [65:0] a, b, p, v;
        logic        [65:0] ma, mb, m, q;
        logic               ovf;
        a   = w.operand_a;
        b   = w.operand_b;
        ovf = 1'b0;
        r   = '0;
        case (w.mode)
            MODE_ADD: r.result = sat32(a + b, ovf);
            MODE_SUB: r.result = sat32(a - b, ovf);
            MODE_MUL: begin
                p = a * b;
                m = (p < 0) ? -p : p;
                m = (m + (66'd1 << (FRAC - 1))) >> FRAC;
                v = (p < 0) ? -$signed(m) : $signed(m);
                r.result = sat32(v, ovf);
            end
            MODE_DIV: begin
                if (b == 0) begin
                    r.divide_by_zero = 1'b1;
                    r.result = (a < 0) ? FX_MIN : FX_MAX;
                end else begin
                    ma = (a < 0) ? -a : a;
                    mb = (b < 0) ? -b : b;
                    q  = ((ma << (FRAC + 1)) + mb) / (mb << 1);
                    v  = ((a < 0) != (b < 0)) ? -$signed(q) : $signed(q);
                    r.result = sat32(v, ovf);
                end
            end
            MODE_GT: r.compare_true = a > b;
            MODE_LT: r.compare_true = a < b;
            MODE_GE: r.compare_true = a >= b;
            MODE_LE: r.compare_true = a <= b;
            MODE_EQ: r.compare_true = a == b;
            MODE_NE: r.compare_true = a != b;
            MODE_MIN: r.result = (a <= b) ? a[31:0] : b[31:0];
            MODE_MAX: r.result = (a >= b) ? a[31:0] : b[31:0];
            MODE_INC: r.result = sat32(a + 1, ovf);
            MODE_DEC: r.result = sat32(a - 1, ovf);
            MODE_TO_INT: r.result = w.operand_a >>> FRAC;
            default: r.result = sat32(a <<< FRAC, ovf);
        endcase
        r.overflow = ovf;
        return r;
    endfunction

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return FX_MAX - $urandom_range(0, 3);
            1: return FX_MIN + $urandom_range(0, 3);
            2: return $urandom_range(0, 8) - 4;
            3: return {{16{1'b0}}, 16'($urandom)} - 32'd32768;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_word(input t_mode md, input logic [31:0] a,
                              input logic [31:0] b);
        t_alu_in w;
        w.mode      = md;
        w.operand_a = a;
        w.operand_b = b;
        pending_words.push_back(w);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        n_errors++;
        $display("mismatch %s: got %h want %h (result %0d)", what, got, want,
                 n_checked);
    endtask

    // driver: one word per start, random idle bursts until the last part
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (drain_hold) begin
            start <= 1'b0;
        end else if (idle_cycles > 0) begin
            idle_cycles <= idle_cycles - 1;
            start       <= 1'b0;
        end else if (pending_words.size() > 0) begin
            if (idle_on && (pending_words.size() > 200) && ($urandom_range(0, 9) == 0)) begin
                idle_cycles <= $urandom_range(0, 10);
                start       <= 1'b0;
            end else begin
                i_word <= pending_words.pop_front();
                start  <= 1'b1;
            end
        end else begin
            start <= 1'b0;
        end
    end

    // monitor: predict on accept, check on strobe, watchdog
    int wdog;
    always @(posedge i_clk) begin
        t_alu_out exp_r;
        if (i_rst_n) begin
            if ((start && !busy) || o_strobe) begin
                wdog <= 0;
            end else begin
                wdog <= wdog + 1;
            end
            if (start && !busy) begin
                expected_results.push_back(alu_predict(i_word));
                n_sent++;
            end
            if (o_strobe) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected word", o_word.result, '0);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (o_word.result !== exp_r.result)
                        report_mismatch("result", o_word.result, exp_r.result);
                    if (o_word.compare_true !== exp_r.compare_true)
                        report_mismatch("compare_true", o_word.compare_true,
                                        exp_r.compare_true);
                    if (o_word.overflow !== exp_r.overflow)
                        report_mismatch("overflow", o_word.overflow, exp_r.overflow);
                    if (o_word.divide_by_zero !== exp_r.divide_by_zero)
                        report_mismatch("divide_by_zero", o_word.divide_by_zero,
                                        exp_r.divide_by_zero);
                end
                n_checked++;
            end
            if (wdog >= WDOG_LIMIT) begin
                $display("tb_fixed_point_alu: done, errors");
                $finish;
            end
        end
    end

    // stimulus and end of run
    initial begin
        t_mode md;
        int    k;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_word      = '0;
        n_errors    = 0;
        n_sent      = 0;
        n_checked   = 0;
        idle_cycles = 0;
        wdog        = 0;
        drain_hold  = 1'b0;
        idle_on     = 1'b1;

        // directed corners
        queue_word(MODE_ADD, FX_MAX, 32'd1);
        queue_word(MODE_SUB, FX_MIN, 32'd1);
        queue_word(MODE_MUL, FX_MIN, FX_MIN);
        queue_word(MODE_MUL, 32'h0000_0180, 32'hFFFF_FF80);
        queue_word(MODE_MUL, 32'd1, 32'd128);
        queue_word(MODE_DIV, 32'd5, 32'd0);
        queue_word(MODE_DIV, 32'hFFFF_FFFB, 32'd0);
        queue_word(MODE_DIV, 32'd0, 32'd0);
        queue_word(MODE_DIV, FX_MAX, 32'd1);
        queue_word(MODE_DIV, FX_MIN, 32'hFFFF_FFFF);
        queue_word(MODE_DIV, 32'd1, 32'd512);
        queue_word(MODE_GT, FX_MAX, FX_MIN);
        queue_word(MODE_LT, FX_MIN, FX_MAX);
        queue_word(MODE_GE, 32'd7, 32'd7);
        queue_word(MODE_LE, 32'd7, 32'd7);
        queue_word(MODE_EQ, FX_MIN, FX_MIN);
        queue_word(MODE_NE, 32'd0, 32'd1);
        queue_word(MODE_MIN, FX_MAX, FX_MIN);
        queue_word(MODE_MAX, FX_MAX, FX_MIN);
        queue_word(MODE_INC, FX_MAX, 32'hA5A5_A5A5);
        queue_word(MODE_DEC, FX_MIN, 32'h5A5A_5A5A);
        queue_word(MODE_TO_INT, 32'hFFFF_FF01, 32'd0);
        queue_word(MODE_TO_INT, FX_MAX, 32'd0);
        queue_word(MODE_FROM_INT, 32'h0080_0000, 32'd0);
        queue_word(MODE_FROM_INT, 32'hFF7F_FFFF, 32'd0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // hold off until the directed words have all come back
        wait (pending_words.size() == 0);
        @(posedge i_clk);
        drain_hold = 1'b1;
        wait (expected_results.size() == 0);
        drain_hold = 1'b0;

        // random words, mixed operations and operand classes
        for (k = 0; k < N_RANDOM; k++) begin
            md = t_mode'($urandom_range(0, 15));
            queue_word(md, rand_operand(), rand_operand());
        end
        wait (pending_words.size() < 150);
        idle_on = 1'b0;
        wait (pending_words.size() == 0);
        @(posedge i_clk);
        wait (expected_results.size() == 0);
        repeat (DRAIN) @(posedge i_clk);

        $display("sent %0d words over all sixteen operations, checked %0d results",
                 n_sent, n_checked);
        $display("corners: saturation, rounding ties, divide by zero, conversions");
        if (n_errors == 0 && expected_results.size() == 0)
            $display("tb_fixed_point_alu: done, clean");
        else
            $display("tb_fixed_point_alu: done, errors");
        $finish;
    end

endmodule

FILE: files.f
sv/falu_pkg.sv
sv/falu_mul.sv
sv/falu_div.sv
sv/fixed_point_alu.sv
sv/falu_checker.sv
dv/tb_fixed_point_alu.sv
